>>> src/tcw_pkg.sv
// ============================================================================
// tcw_pkg: shared types and constants for the text console writer
// Opcodes, sequencer states, field widths and special character codes.
// ============================================================================
package tcw_pkg;

  // Default screen geometry
  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  // Fixed field widths
  localparam int CHAR_W    = 8;
  localparam int PAIR_W    = 16;
  localparam int COL_W     = 11;
  localparam int COORD_W   = 16;
  localparam int IDX_W     = 11;
  localparam int POS_OUT_W = 11;
  localparam int ROW_OUT_W = 5;

  localparam logic [COL_W-1:0]  COL_MAX = '1;
  localparam logic [CHAR_W-1:0] CODE_CR = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_LF = 8'd10;

  // Configuration register index, taken from paddr[2]
  localparam logic REG_CURSOR_VISIBLE = 1'b0;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_MOVE  = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_CHAR,
    ST_READ,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_RESULT
  } state_t;

endpackage

>>> src/tcw_cell_mem.sv
// ============================================================================
// tcw_cell_mem: character cell store
// Single write port, single read port with registered read data.
// ============================================================================
module tcw_cell_mem #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [tcw_pkg::PAIR_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [tcw_pkg::PAIR_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [PAIR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/text_console_writer.sv
// ============================================================================
// text_console_writer: text-mode screen engine
// Character/attribute cell store with cursor, line feed scrolling and reads.
// ============================================================================
// One transaction in gives one transaction out. After reset the block sweeps
// the cell store once to clear it, with s_tready low; configuration writes
// are taken during the sweep. Every item then runs through a small sequencer
// that owns one position adder (row*COLS plus column, or scroll source
// address) and a cell memory with one write port, one read port and
// registered read data. From ST_IDLE an accepted item goes to ST_EXEC; a
// cursor move, a cell read at or past the screen end or an unused opcode then
// goes to ST_RESULT, a cell read on the screen passes through ST_READ, and a
// character write passes through ST_CHAR. A line feed on the bottom row
// scrolls: each of the COLS*(ROWS-1) surviving cells is read in ST_SCROLL_RD
// and written one row up in ST_SCROLL_WR, then the bottom row is blanked one
// cell at a time before ST_RESULT. s_tready is high only while the sequencer
// is idle; a finished result waits in the output register while the next
// transaction is accepted and worked on, and a result that finds the output
// register still full holds the sequencer until m_tready frees it.
module text_console_writer #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] char_code, [15:8] attribute, [16] starts_call, [32:17] target_col,
  // [48:33] target_row, [59:49] cell_index, [63:60] zero
  input  logic [63:0] s_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] read_cell, [26:16] cursor_position, [37:27] cursor_col_out,
  // [42:38] cursor_row_out, [43] write_dropped, [47:44] zero
  output logic [47:0] m_tdata,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcw_pkg::*;

  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int POS_W  = $clog2(CELLS + 2048);

  localparam logic [POS_W-1:0]  POS_CELLS     = POS_W'(CELLS);
  localparam logic [ADDR_W-1:0] ADDR_LAST     = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ADDR_COPY_END = ADDR_W'(CELLS - COLS);
  localparam logic [ROW_W-1:0]  ROW_LAST      = ROW_W'(ROWS - 1);

  // Sequencer and cursor state
  state_t            state, state_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic              cursor_visible;

  // Latched transaction payload
  opcode_t            op;
  logic [CHAR_W-1:0]  ch;
  logic [CHAR_W-1:0]  attr;
  logic               start;
  logic [COORD_W-1:0] tcol;  // two's complement
  logic [COORD_W-1:0] trow;  // two's complement
  logic [IDX_W-1:0]   idx;

  logic [PAIR_W-1:0] rd, rd_next;
  logic              dropped, dropped_next;

  // Output register
  logic        out_valid;
  logic [47:0] out_data;
  logic        out_load;

  // Cell memory port
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [PAIR_W-1:0] mem_wdata, mem_rdata;

  // Shared position adder
  logic [POS_W-1:0] row_base;
  logic [POS_W-1:0] add_a, add_b, add_sum;
  logic             pos_ge;
  logic [POS_W-1:0] pos_report;

  logic in_accept;
  logic cfg_write;

  assign in_accept = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_CURSOR_VISIBLE) ? 32'(cursor_visible) : '0;

  // --------------------------------------------------------------------------
  // Position adder: linear cursor position, or scroll source (ptr + COLS)
  // --------------------------------------------------------------------------
  assign row_base = POS_W'(row) * POS_W'(COLS);

  always_comb begin
    if (state == ST_SCROLL_RD) begin
      add_a = POS_W'(ptr);
      add_b = POS_W'(COLS);
    end else begin
      add_a = row_base;
      add_b = POS_W'(col);
    end
    add_sum = add_a + add_b;
  end

  assign pos_ge = (add_sum >= POS_CELLS);

  // Hidden cursor reports the screen size; a visible one saturates there
  assign pos_report = (cursor_visible && !pos_ge) ? add_sum : POS_CELLS;

  // --------------------------------------------------------------------------
  // Sequencer: next state, cursor updates and memory control
  // --------------------------------------------------------------------------
  always_comb begin
    state_next   = state;
    ptr_next     = ptr;
    col_next     = col;
    row_next     = row;
    rd_next      = rd;
    dropped_next = dropped;
    mem_we       = 1'b0;
    mem_waddr    = ptr;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = ADDR_W'(add_sum);
    out_load     = 1'b0;

    case (state)
      ST_CLEAR: begin
        // Zero one cell per cycle after reset
        mem_we = 1'b1;
        if (ptr == ADDR_LAST) begin
          ptr_next   = '0;
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          rd_next      = '0;
          dropped_next = 1'b0;
          state_next   = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (op)
          OP_WRITE: begin
            // Call start with the cursor off screen: go home first
            if (start && pos_ge) begin
              col_next = '0;
              row_next = '0;
            end
            state_next = ST_CHAR;
          end
          OP_MOVE: begin
            if (!tcol[COORD_W-1] && (tcol <= COORD_W'(COLS))) begin
              col_next = tcol[COL_W-1:0];
            end else begin
              col_next = '0;
            end
            if (!trow[COORD_W-1] && (trow < COORD_W'(ROWS))) begin
              row_next = ROW_W'(trow);
            end else begin
              row_next = '0;
            end
            state_next = ST_RESULT;
          end
          OP_READ: begin
            if (POS_W'(idx) < POS_CELLS) begin
              mem_re     = 1'b1;
              mem_raddr  = ADDR_W'(idx);
              state_next = ST_READ;
            end else begin
              state_next = ST_RESULT;
            end
          end
          default: begin
            state_next = ST_RESULT;
          end
        endcase
      end

      ST_READ: begin
        rd_next    = mem_rdata;
        state_next = ST_RESULT;
      end

      ST_CHAR: begin
        if (ch == CODE_CR) begin
          col_next   = '0;
          state_next = ST_RESULT;
        end else if (ch == CODE_LF) begin
          col_next = '0;
          if (row == ROW_LAST) begin
            ptr_next   = '0;
            state_next = ST_SCROLL_RD;
          end else begin
            row_next   = row + 1'b1;
            state_next = ST_RESULT;
          end
        end else begin
          if (!pos_ge) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(add_sum);
            mem_wdata = {attr, ch};
          end else begin
            dropped_next = 1'b1;
          end
          if (col != COL_MAX) begin
            col_next = col + 1'b1;
          end
          state_next = ST_RESULT;
        end
      end

      ST_SCROLL_RD: begin
        if (ptr < ADDR_COPY_END) begin
          // Fetch the cell one row below
          mem_re     = 1'b1;
          state_next = ST_SCROLL_WR;
        end else begin
          // Blank the bottom row
          mem_we = 1'b1;
          if (ptr == ADDR_LAST) begin
            ptr_next   = '0;
            state_next = ST_RESULT;
          end else begin
            ptr_next = ptr + 1'b1;
          end
        end
      end

      ST_SCROLL_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = mem_rdata;
        ptr_next   = ptr + 1'b1;
        state_next = ST_SCROLL_RD;
      end

      ST_RESULT: begin
        // Wait for a free output slot
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      ptr            <= '0;
      col            <= '0;
      row            <= '0;
      cursor_visible <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      col   <= col_next;
      row   <= row_next;
      if (cfg_write && (paddr[2] == REG_CURSOR_VISIBLE)) begin
        cursor_visible <= pwdata[0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd      <= rd_next;
    dropped <= dropped_next;
    if (in_accept) begin
      op    <= opcode_t'(s_tuser);
      ch    <= s_tdata[7:0];
      attr  <= s_tdata[15:8];
      start <= s_tdata[16];
      tcol  <= s_tdata[32:17];
      trow  <= s_tdata[48:33];
      idx   <= s_tdata[59:49];
    end
    if (out_load) begin
      out_data <= {4'b0, dropped, ROW_OUT_W'(row), col,
                   pos_report[POS_OUT_W-1:0], rd};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  tcw_cell_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_cell_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

`ifndef SYNTHESIS
  // Never write outside the cell store
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (mem_waddr <= ADDR_LAST))
    else $error("cell write beyond the screen");

  // Cursor row stays on the screen
  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> (row <= ROW_LAST))
    else $error("cursor row past the last row");

  // A scroll write always follows its read
  a_scroll_pairing: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCROLL_WR) |-> ($past(state) == ST_SCROLL_RD))
    else $error("scroll write without a preceding read");

  // Only a character write can be flagged as dropped
  a_drop_only_write: assert property (@(posedge clk) disable iff (rst)
    (out_load && dropped) |-> (op == OP_WRITE))
    else $error("dropped flag on a non-write transaction");
`endif

endmodule

>>> tb/text_console_writer_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// text_console_writer_tb: self-checking testbench for the text console writer
// Drives command transactions on the input stream and predicts every result
// with a behavioral copy of the screen store, the cursor and the visibility
// register. Results are compared field by field, in order, as they leave the
// block. The tests cover directed corner cases, the visibility register, long
// random traffic with idle and stall gaps, and a column run past the screen end.
// ============================================================================
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int COLS  = COLS_DEF;
  localparam int ROWS  = ROWS_DEF;
  localparam int CELLS = COLS * ROWS;

  // Opcode value left free by the package enum; the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Byte address of the visibility register on the config port
  localparam logic [2:0] VIS_ADDR = {REG_CURSOR_VISIBLE, 2'b00};

  // Cycles to let pass after the last result before touching the config port
  localparam int SETTLE_CYCLES = 4;
  // Cycles to let pass after the final result before deciding the verdict
  localparam int TAIL_CYCLES   = 20;
  // Print at most this many mismatch lines; keep counting past it
  localparam int MAX_REPORTS   = 50;

  // One command transaction on the input stream
  typedef struct {
    logic [1:0]                op;
    logic [CHAR_W-1:0]         ch;
    logic [CHAR_W-1:0]         attr;
    logic                      starts;
    logic signed [COORD_W-1:0] tcol;
    logic signed [COORD_W-1:0] trow;
    logic [IDX_W-1:0]          idx;
  } console_cmd_t;

  // One predicted result transaction
  typedef struct {
    logic [PAIR_W-1:0]    pair_rd;
    logic [POS_OUT_W-1:0] pos;
    logic [COL_W-1:0]     col;
    logic [ROW_OUT_W-1:0] row;
    logic                 dropped;
  } console_view_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; every input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [7:0] char_code, [15:8] attribute, [16] starts_call, [32:17] target_col,
  // [48:33] target_row, [59:49] cell_index, [63:60] zero
  logic [63:0] s_tdata  = '0;
  // [1:0] opcode
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [15:0] read_cell, [26:16] cursor_position, [37:27] cursor_col_out,
  // [42:38] cursor_row_out, [43] write_dropped, [47:44] zero
  logic [47:0] m_tdata;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted state of the screen engine
  logic [PAIR_W-1:0]    scr_mem [CELLS];
  logic [COL_W-1:0]     cur_col;
  logic [ROW_OUT_W-1:0] cur_row;
  logic                 pred_visible;

  // Results still owed by the block, oldest first
  console_view_t pending_views[$];
  int            mismatches = 0;
  // Suppress idling on both sides while set
  bit            no_idle    = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  text_console_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Screen predictor
  // --------------------------------------------------------------------------
  function automatic int cursor_linear();
    return int'(cur_row) * COLS + int'(cur_col);
  endfunction

  // Shift every row up by one and blank the bottom row
  task automatic scroll_screen_up();
    for (int i = 0; i < CELLS - COLS; i++) scr_mem[i] = scr_mem[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) scr_mem[i] = '0;
  endtask

  task automatic predict_console(input console_cmd_t c, output console_view_t v);
    int lin;
    int tc;
    int tr;
    v  = '{default: '0};
    tc = c.tcol;
    tr = c.trow;
    case (c.op)
      OP_WRITE: begin
        // A new call homes a cursor that sits at or past the screen end
        if (c.starts && cursor_linear() >= CELLS) begin
          cur_col = '0;
          cur_row = '0;
        end
        if (c.ch == CODE_CR) begin
          cur_col = '0;
        end else if (c.ch == CODE_LF) begin
          if (int'(cur_row) + 1 < ROWS) cur_row = cur_row + 1'b1;
          else scroll_screen_up();
          cur_col = '0;
        end else begin
          lin = cursor_linear();
          if (lin < CELLS) scr_mem[lin] = {c.attr, c.ch};
          else v.dropped = 1'b1;
          // Column advances with no wrap and sticks at its top value
          if (cur_col != COL_MAX) cur_col = cur_col + 1'b1;
        end
      end
      OP_MOVE: begin
        // Column may equal COLS; each coordinate is range-checked on its own
        cur_col = (tc < 0 || tc > COLS) ? '0 : COL_W'(tc);
        cur_row = (tr < 0 || tr >= ROWS) ? '0 : ROW_OUT_W'(tr);
      end
      OP_READ: begin
        if (int'(c.idx) < CELLS) v.pair_rd = scr_mem[c.idx];
      end
      default: ;
    endcase
    lin     = cursor_linear();
    v.pos   = pred_visible ? POS_OUT_W'((lin > CELLS) ? CELLS : lin) : POS_OUT_W'(CELLS);
    v.col   = cur_col;
    v.row   = cur_row;
  endtask

  // --------------------------------------------------------------------------
  // Reporting and result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    if (mismatches < MAX_REPORTS)
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Stall the result stream at random unless a quiet stretch is running
  always @(posedge clk) begin
    if (no_idle) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(99) >= 14);
  end

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    console_view_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_views.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, '0);
      end else begin
        want = pending_views.pop_front();
        if (m_tdata[15:0] !== want.pair_rd)
          report_mismatch("read_cell", m_tdata[15:0], want.pair_rd);
        if (m_tdata[26:16] !== want.pos)
          report_mismatch("cursor_position", m_tdata[26:16], want.pos);
        if (m_tdata[37:27] !== want.col)
          report_mismatch("cursor_col_out", m_tdata[37:27], want.col);
        if (m_tdata[42:38] !== want.row)
          report_mismatch("cursor_row_out", m_tdata[42:38], want.row);
        if (m_tdata[43] !== want.dropped)
          report_mismatch("write_dropped", m_tdata[43], want.dropped);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic console_cmd_t make_cmd(input logic [1:0] op, input int ch,
                                            input int attr, input bit starts,
                                            input int tcol, input int trow,
                                            input int idx);
    console_cmd_t c;
    c.op     = op;
    c.ch     = CHAR_W'(ch);
    c.attr   = CHAR_W'(attr);
    c.starts = starts;
    c.tcol   = COORD_W'(tcol);
    c.trow   = COORD_W'(trow);
    c.idx    = IDX_W'(idx);
    return c;
  endfunction

  // Random fields, opcode drawn from the three defined ones; callers override what the opcode uses
  function automatic console_cmd_t noise_cmd();
    console_cmd_t c;
    c.op     = 2'($urandom_range(0, 2));
    c.ch     = CHAR_W'($urandom);
    c.attr   = CHAR_W'($urandom);
    c.starts = 1'($urandom);
    c.tcol   = COORD_W'($urandom);
    c.trow   = COORD_W'($urandom);
    c.idx    = IDX_W'($urandom);
    return c;
  endfunction

  // Any byte except the two control codes
  function automatic logic [CHAR_W-1:0] plain_glyph();
    logic [CHAR_W-1:0] g;
    do g = CHAR_W'($urandom); while (g == CODE_CR || g == CODE_LF);
    return g;
  endfunction

  // Text-like bytes with a light sprinkling of CR and LF
  function automatic logic [CHAR_W-1:0] text_glyph();
    int r;
    r = $urandom_range(99);
    if (r < 4) return CODE_LF;
    if (r < 8) return CODE_CR;
    if (r < 80) return CHAR_W'($urandom_range(32, 126));
    return plain_glyph();
  endfunction

  // Send one command transaction and record its predicted result.
  // Valid stays high on return so back-to-back items need no extra NBA.
  task automatic send_item(input console_cmd_t c);
    console_view_t v;
    if (!no_idle && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.op;
    s_tdata  <= {4'b0000, c.idx, c.trow, c.tcol, c.starts, c.attr, c.ch};
    do @(posedge clk); while (!s_tready);
    predict_console(c, v);
    pending_views.push_back(v);
  endtask

  // Drop valid and hold until every predicted result has been seen
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // One config transfer: setup phase, access phase, then back to idle
  task automatic apb_xfer(input bit wr, input logic [2:0] addr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata    = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_visible_reg(input logic want);
    logic [31:0] rd;
    apb_xfer(1'b0, VIS_ADDR, '0, rd);
    if (rd !== {31'b0, want}) report_mismatch("cursor_visible readback", rd, want);
  endtask

  // Write the visibility register only once the block has gone quiet
  task automatic set_cursor_visible(input logic vis);
    logic [31:0] rd;
    settle_idle();
    apb_xfer(1'b1, VIS_ADDR, {31'b0, vis}, rd);
    pred_visible = vis;
    check_visible_reg(vis);
  endtask

  // Random traffic: mostly write calls with text content, plus moves,
  // reads biased toward written cells, and some items of pure noise
  task automatic drive_random_mix(input int count);
    int           sent;
    int           pick;
    int           len;
    int           hi;
    console_cmd_t c;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          c        = noise_cmd();
          c.op     = OP_WRITE;
          c.starts = (k == 0);
          c.ch     = text_glyph();
          send_item(c);
          sent++;
        end
      end else if (pick < 70) begin
        c    = noise_cmd();
        c.op = OP_MOVE;
        if ($urandom_range(9) < 8) begin
          c.tcol = COORD_W'($urandom_range(0, COLS));
          c.trow = COORD_W'($urandom_range(0, ROWS - 1));
        end
        send_item(c);
        sent++;
      end else if (pick < 92) begin
        c    = noise_cmd();
        c.op = OP_READ;
        hi   = cursor_linear();
        if (hi > CELLS) hi = CELLS;
        pick = $urandom_range(99);
        if (pick < 50 && hi > 0) c.idx = IDX_W'($urandom_range(0, hi - 1));
        else if (pick < 85) c.idx = IDX_W'($urandom_range(0, CELLS - 1));
        else c.idx = IDX_W'($urandom_range(CELLS, (1 << IDX_W) - 1));
        send_item(c);
        sent++;
      end else begin
        send_item(noise_cmd());
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, every opcode, control codes, homing, drops, scrolling
  task automatic test_directed_cases();
    // cleared store reads zero
    send_item(make_cmd(OP_READ, 0, 0, 1'b0, 0, 0, 0));
    send_item(make_cmd(OP_WRITE, 8'h00, 8'h00, 1'b1, 0, 0, 0));
    send_item(make_cmd(OP_WRITE, 8'hFF, 8'hFF, 1'b0, 0, 0, 0));
    send_item(make_cmd(OP_READ, 0, 0, 1'b0, 0, 0, 1));
    // index past the screen reads zero
    send_item(make_cmd(OP_READ, 0, 0, 1'b0, 0, 0, 2047));
    send_item(make_cmd(OP_WRITE, CODE_CR, 8'h5A, 1'b0, 0, 0, 0));
    send_item(make_cmd(OP_WRITE, CODE_LF, 8'hA5, 1'b0, 0, 0, 0));
    send_item(make_cmd(OP_WRITE, 8'h41, 8'h1F, 1'b0, 0, 0, 0));
    send_item(make_cmd(OP_READ, 0, 0, 1'b0, 0, 0, COLS));
    // cursor parked right at the screen end: a plain pair is dropped,
    // then the next call start sends it home
    send_item(make_cmd(OP_MOVE, 0, 0, 1'b0, COLS, ROWS - 1, 0));
    send_item(make_cmd(OP_WRITE, 8'h58, 8'h07, 1'b0, 0, 0, 0));
    send_item(make_cmd(OP_WRITE, 8'h59, 8'h70, 1'b1, 0, 0, 0));
    send_item(make_cmd(OP_READ, 0, 0, 1'b0, 0, 0, 0));
    // out-of-range move targets, each coordinate on its own
    send_item(make_cmd(OP_MOVE, 0, 0, 1'b0, -1, -32768, 0));
    send_item(make_cmd(OP_MOVE, 0, 0, 1'b0, COLS + 1, ROWS, 0));
    send_item(make_cmd(OP_MOVE, 0, 0, 1'b0, 32767, ROWS - 1, 0));
    send_item(make_cmd(OP_MOVE, 0, 0, 1'b0, -32768, 32767, 0));
    // last cell, then a line feed on the bottom row scrolls everything up
    send_item(make_cmd(OP_MOVE, 0, 0, 1'b0, COLS - 1, ROWS - 1, 0));
    send_item(make_cmd(OP_WRITE, 8'h5A, 8'h4E, 1'b0, 0, 0, 0));
    send_item(make_cmd(OP_WRITE, CODE_LF, 8'h00, 1'b0, 0, 0, 0));
    send_item(make_cmd(OP_READ, 0, 0, 1'b0, 0, 0, CELLS - COLS - 1));
    send_item(make_cmd(OP_READ, 0, 0, 1'b0, 0, 0, CELLS - 1));
    // free opcode changes nothing
    send_item(make_cmd(OP_UNUSED, 8'h41, 8'hFF, 1'b1, 5, 5, 3));
    // call start on a line feed homes first, then moves down one row
    send_item(make_cmd(OP_MOVE, 0, 0, 1'b0, COLS, ROWS - 1, 0));
    send_item(make_cmd(OP_WRITE, CODE_LF, 8'h00, 1'b1, 0, 0, 0));
  endtask

  // Reset value, hidden cursor reporting the screen size, and restore
  task automatic test_visibility_register();
    settle_idle();
    check_visible_reg(1'b1);
    set_cursor_visible(1'b1);
    set_cursor_visible(1'b0);
    send_item(make_cmd(OP_MOVE, 0, 0, 1'b0, 3, 2, 0));
    send_item(make_cmd(OP_WRITE, 8'h62, 8'h21, 1'b1, 0, 0, 0));
    send_item(make_cmd(OP_MOVE, 0, 0, 1'b0, COLS, ROWS - 1, 0));
    send_item(make_cmd(OP_WRITE, 8'h63, 8'h12, 1'b0, 0, 0, 0));
    drive_random_mix(40);
    set_cursor_visible(1'b1);
  endtask

  // Long random run with a quiet stretch, a hidden-cursor phase and a hold
  task automatic test_random_traffic();
    drive_random_mix(280);
    no_idle = 1'b1;
    drive_random_mix(130);
    no_idle = 1'b0;
    set_cursor_visible(1'b0);
    drive_random_mix(110);
    // hold the sender until every outstanding result is back
    settle_idle();
    drive_random_mix(90);
    set_cursor_visible(1'b1);
    drive_random_mix(210);
  endtask

  // Walk the column on past the screen end; every pair there is dropped
  task automatic test_column_saturation();
    console_cmd_t c;
    send_item(make_cmd(OP_MOVE, 0, 0, 1'b0, COLS, ROWS - 1, 0));
    for (int i = 0; i < 40; i++) begin
      c        = noise_cmd();
      c.op     = OP_WRITE;
      c.starts = 1'b0;
      c.ch     = plain_glyph();
      send_item(c);
    end
    send_item(make_cmd(OP_WRITE, 8'h21, 8'hC3, 1'b1, 0, 0, 0));
    send_item(make_cmd(OP_READ, 0, 0, 1'b0, 0, 0, 0));
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < CELLS; i++) scr_mem[i] = '0;
    cur_col      = '0;
    cur_row      = '0;
    pred_visible = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_visibility_register();
    test_random_traffic();
    test_column_saturation();

    // drain, then give the block a short tail to show any stray result
    settle_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, even with a scroll on every item
  initial begin
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
